### hdl/assert_macros.svh
// Assertion macros used by the flow tracker top level.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif
`endif

### hdl/fftr_pkg.sv
// Types and constants for the five-tuple flow tracker.
// No dependencies.
package fftr_pkg;

    localparam int DEF_FLOW_ENTRIES = 256;

    localparam logic [7:0] PROTO_TCP     = 8'd6;
    localparam logic [7:0] PROTO_UDP     = 8'd17;
    localparam logic [7:0] ETH_HDR_BYTES = 8'd14;
    localparam logic [7:0] UDP_HDR_BYTES = 8'd8;

    typedef enum logic [1:0] {
        KIND_SKIP = 2'd0,
        KIND_TCP  = 2'd1,
        KIND_UDP  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0]  ip_protocol;
        logic [3:0]  ip_header_words;
        logic [3:0]  tcp_data_offset;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port_num;
        logic [15:0] dest_port_num;
        logic [15:0] frame_length;
    } in_t;

    typedef struct packed {
        logic [1:0]  packet_kind;
        logic        flow_is_new;
        logic        table_full;
        logic [7:0]  flow_slot;
        logic [15:0] payload_bytes;
        logic [31:0] total_packets;
        logic [31:0] tcp_packets;
        logic [31:0] udp_packets;
        logic [31:0] tcp_byte_total;
        logic [31:0] udp_byte_total;
        logic [8:0]  tcp_flows;
        logic [8:0]  udp_flows;
    } out_t;

    typedef struct packed {
        logic        udp;
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [31:0] ports;
    } flow_key_t;

    typedef struct packed {
        logic      vld;
        logic      tracked;
        flow_key_t key;
    } tok_t;

    typedef struct packed {
        logic hit;
        logic ins;
    } stat_t;

    typedef struct packed {
        logic [31:0] total;
        logic [31:0] tcp_pkts;
        logic [31:0] udp_pkts;
        logic [31:0] tcp_len_sum;
        logic [31:0] udp_len_sum;
    } cnt_t;

endpackage

### hdl/five_tuple_flow_tracker.sv
// Five-tuple flow tracker: packet statistics and a flow table built as a chain of cells.
// Depends on fftr_pkg, fftr_front, fftr_cell and assert_macros.svh.
//
// Usage:
//   pkt carries the parsed header fields of one packet; it transfers on a
//   rising edge with pkt_valid high and pkt_stall low. res carries one result
//   per packet; it transfers with res_valid high and res_stall low.
//   One packet is in flight at a time: pkt_stall stays high from the input
//   transfer until its result has transferred.
//   The front stage registers the packet, then the lookup walks the cell
//   chain, one cell per cycle, each cell holding one stored flow, and the
//   result is registered in the output register.
//   A stalled result holds in the output register until taken.
//   Reset clears all counters and empties the table; stored tuples keep no
//   reset value and are never compared before they are written.
`include "assert_macros.svh"
module five_tuple_flow_tracker #(
    parameter int FLOW_ENTRIES = fftr_pkg::DEF_FLOW_ENTRIES
) (
    input  logic           clk,
    input  logic           rst_n,
    input  fftr_pkg::in_t  pkt,
    input  logic           pkt_valid,
    output logic           pkt_stall,
    output fftr_pkg::out_t res,
    output logic           res_valid,
    input  logic           res_stall
);
    import fftr_pkg::*;

    localparam int SLOT_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(FLOW_ENTRIES + 1);

    logic              busy_reg, busy_next;
    logic              out_vld_reg, out_vld_next;
    out_t              res_reg, res_next;
    logic [CNT_W-1:0]  flow_cnt_reg, flow_cnt_next;
    logic [CNT_W-1:0]  tcp_flows_reg, tcp_flows_next;
    logic [CNT_W-1:0]  udp_flows_reg, udp_flows_next;
    logic              accept, transfer;
    logic [CNT_W:0]    flows_sum;

    tok_t              tok_chain  [FLOW_ENTRIES+1];
    stat_t             stat_chain [FLOW_ENTRIES+1];
    logic [SLOT_W-1:0] slot_chain [FLOW_ENTRIES+1];
    logic [FLOW_ENTRIES+1:0] vld_vec;

    kind_t             kind;
    logic [15:0]       payload;
    cnt_t              cnt;
    tok_t              tail;
    stat_t             tail_st;
    logic [SLOT_W-1:0] tail_slot;

    assign accept   = pkt_valid && !busy_reg;
    assign transfer = out_vld_reg && !res_stall;

    fftr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .pkt     (pkt),
        .tok     (tok_chain[0]),
        .kind    (kind),
        .payload (payload),
        .cnt     (cnt)
    );

    assign stat_chain[0] = '0;
    assign slot_chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < FLOW_ENTRIES; gi++)
        begin : g_cell
            fftr_cell #(
                .IDX    (gi),
                .CNT_W  (CNT_W),
                .SLOT_W (SLOT_W)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .flow_cnt (flow_cnt_reg),
                .tok_in   (tok_chain[gi]),
                .stat_in  (stat_chain[gi]),
                .slot_in  (slot_chain[gi]),
                .tok_out  (tok_chain[gi+1]),
                .stat_out (stat_chain[gi+1]),
                .slot_out (slot_chain[gi+1])
            );
        end
        for (gi = 0; gi <= FLOW_ENTRIES; gi++)
        begin : g_vld
            assign vld_vec[gi] = tok_chain[gi].vld;
        end
    endgenerate

    assign vld_vec[FLOW_ENTRIES+1] = out_vld_reg;

    assign tail      = tok_chain[FLOW_ENTRIES];
    assign tail_st   = stat_chain[FLOW_ENTRIES];
    assign tail_slot = slot_chain[FLOW_ENTRIES];

    assign flows_sum = (CNT_W+1)'(tcp_flows_reg) + (CNT_W+1)'(udp_flows_reg);

    always_comb
    begin
        flow_cnt_next  = flow_cnt_reg;
        tcp_flows_next = tcp_flows_reg;
        udp_flows_next = udp_flows_reg;
        if (tail.vld && tail.tracked && !tail_st.hit && tail_st.ins)
        begin
            flow_cnt_next = flow_cnt_reg + CNT_W'(1);
            if (tail.key.udp)
            begin
                udp_flows_next = udp_flows_reg + CNT_W'(1);
            end
            else
            begin
                tcp_flows_next = tcp_flows_reg + CNT_W'(1);
            end
        end

        res_next                = res_reg;
        res_next.packet_kind    = kind;
        res_next.flow_is_new    = tail.tracked && !tail_st.hit;
        res_next.table_full     = tail.tracked && !tail_st.hit && !tail_st.ins;
        res_next.flow_slot      = (tail.tracked && (tail_st.hit || tail_st.ins))
                                ? 8'(tail_slot) : 8'd0;
        res_next.payload_bytes  = payload;
        res_next.total_packets  = cnt.total;
        res_next.tcp_packets    = cnt.tcp_pkts;
        res_next.udp_packets    = cnt.udp_pkts;
        res_next.tcp_byte_total = cnt.tcp_len_sum;
        res_next.udp_byte_total = cnt.udp_len_sum;
        res_next.tcp_flows      = 9'(tcp_flows_next);
        res_next.udp_flows      = 9'(udp_flows_next);

        out_vld_next = out_vld_reg;
        if (tail.vld)
        begin
            out_vld_next = 1'b1;
        end
        else if (transfer)
        begin
            out_vld_next = 1'b0;
        end

        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (transfer)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_vld_reg   <= 1'b0;
            flow_cnt_reg  <= '0;
            tcp_flows_reg <= '0;
            udp_flows_reg <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_vld_reg   <= out_vld_next;
            flow_cnt_reg  <= flow_cnt_next;
            tcp_flows_reg <= tcp_flows_next;
            udp_flows_reg <= udp_flows_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail.vld)
        begin
            res_reg <= res_next;
        end
    end

    assign pkt_stall = busy_reg;
    assign res_valid = out_vld_reg;
    assign res       = res_reg;

    `ASSERT_IMPLIES(a_res_while_busy, out_vld_reg, busy_reg, "result valid while not busy")
    `ASSERT_IMPLIES(a_no_overwrite, tail.vld, !out_vld_reg, "pending result overwritten")
    `ASSERT_ALWAYS(a_one_in_flight, $onehot0(vld_vec), "more than one lookup in flight")
    `ASSERT_ALWAYS(a_cnt_bound, flow_cnt_reg <= CNT_W'(FLOW_ENTRIES), "flow count above size")
    `ASSERT_ALWAYS(a_cnt_sum, flows_sum == (CNT_W+1)'(flow_cnt_reg), "flow counts disagree")

endmodule

### hdl/fftr_front.sv
// Input stage: classifies the packet, computes payload length, keeps packet counters.
// Depends on fftr_pkg.
module fftr_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  fftr_pkg::in_t  pkt,
    output fftr_pkg::tok_t tok,
    output fftr_pkg::kind_t kind,
    output logic [15:0]    payload,
    output fftr_pkg::cnt_t cnt
);
    import fftr_pkg::*;

    logic        vld_reg, vld_next;
    tok_t        tok_reg, tok_next;
    kind_t       kind_reg, kind_next;
    logic [15:0] payload_reg, payload_next;
    cnt_t        cnt_reg, cnt_next;
    logic        is_tcp, is_udp;
    logic [7:0]  hdr_len;

    always_comb
    begin
        is_tcp  = (pkt.ip_protocol == PROTO_TCP);
        is_udp  = (pkt.ip_protocol == PROTO_UDP);
        hdr_len = ETH_HDR_BYTES + {2'b00, pkt.ip_header_words, 2'b00}
                + (is_udp ? UDP_HDR_BYTES : {2'b00, pkt.tcp_data_offset, 2'b00});

        vld_next             = accept;
        tok_next.vld         = accept;
        tok_next.tracked     = is_tcp || is_udp;
        tok_next.key.udp     = is_udp;
        tok_next.key.saddr   = pkt.source_address;
        tok_next.key.daddr   = pkt.dest_address;
        tok_next.key.ports   = {pkt.source_port_num, pkt.dest_port_num};

        kind_next    = is_udp ? KIND_UDP : (is_tcp ? KIND_TCP : KIND_SKIP);
        payload_next = '0;
        if ((is_tcp || is_udp) && (pkt.frame_length > 16'(hdr_len)))
        begin
            payload_next = pkt.frame_length - 16'(hdr_len);
        end

        cnt_next = cnt_reg;
        cnt_next.total = cnt_reg.total + 32'd1;
        if (is_tcp)
        begin
            cnt_next.tcp_pkts    = cnt_reg.tcp_pkts + 32'd1;
            cnt_next.tcp_len_sum = cnt_reg.tcp_len_sum + 32'(pkt.frame_length);
        end
        if (is_udp)
        begin
            cnt_next.udp_pkts    = cnt_reg.udp_pkts + 32'd1;
            cnt_next.udp_len_sum = cnt_reg.udp_len_sum + 32'(pkt.frame_length);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (accept)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tok_reg     <= tok_next;
            kind_reg    <= kind_next;
            payload_reg <= payload_next;
        end
    end

    always_comb
    begin
        tok         = tok_reg;
        tok.vld     = vld_reg;
        kind        = kind_reg;
        payload     = payload_reg;
        cnt         = cnt_reg;
    end

endmodule

### hdl/fftr_cell.sv
// One flow table cell: holds one stored 5-tuple, compares or inserts, passes the lookup on.
// Depends on fftr_pkg.
module fftr_cell #(
    parameter int IDX    = 0,
    parameter int CNT_W  = 9,
    parameter int SLOT_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CNT_W-1:0]  flow_cnt,
    input  fftr_pkg::tok_t    tok_in,
    input  fftr_pkg::stat_t   stat_in,
    input  logic [SLOT_W-1:0] slot_in,
    output fftr_pkg::tok_t    tok_out,
    output fftr_pkg::stat_t   stat_out,
    output logic [SLOT_W-1:0] slot_out
);
    import fftr_pkg::*;

    logic              vld_reg, vld_next;
    tok_t              tok_reg, tok_next;
    stat_t             stat_reg, stat_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    flow_key_t         entry_reg;
    logic              occupied, empty_here, match, pending, wr_en;

    always_comb
    begin
        occupied   = (CNT_W'(IDX) < flow_cnt);
        empty_here = (CNT_W'(IDX) == flow_cnt);
        match      = occupied && (entry_reg == tok_in.key);
        pending    = tok_in.vld && tok_in.tracked && !stat_in.hit && !stat_in.ins;
        wr_en      = pending && !match && empty_here;

        vld_next  = tok_in.vld;
        tok_next  = tok_in;
        stat_next = stat_in;
        slot_next = slot_in;
        if (pending && match)
        begin
            stat_next.hit = 1'b1;
            slot_next     = SLOT_W'(IDX);
        end
        else if (wr_en)
        begin
            stat_next.ins = 1'b1;
            slot_next     = SLOT_W'(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg  <= tok_next;
        stat_reg <= stat_next;
        slot_reg <= slot_next;
        if (wr_en)
        begin
            entry_reg <= tok_in.key;
        end
    end

    always_comb
    begin
        tok_out     = tok_reg;
        tok_out.vld = vld_reg;
        stat_out    = stat_reg;
        slot_out    = slot_reg;
    end

endmodule

### verif/five_tuple_flow_tracker_tb.sv
// Testbench for five_tuple_flow_tracker: directed and random packet headers, with results
// checked against a flow table and counter model kept in a scoreboard class.
// Depends on fftr_pkg and the five_tuple_flow_tracker RTL.
`timescale 1ns / 100ps
module five_tuple_flow_tracker_tb;
    import fftr_pkg::*;

    localparam int RANDOM_PACKETS = 1430;
    localparam int DRAIN_CYCLES   = DEF_FLOW_ENTRIES + 16;
    localparam int CYCLE_LIMIT    = 5_000_000;

    class flow_scoreboard;
        flow_key_t   stored_flows[$];
        out_t        pending_results[$];
        logic [31:0] total_cnt;
        logic [31:0] tcp_pkt_cnt;
        logic [31:0] udp_pkt_cnt;
        logic [31:0] tcp_byte_cnt;
        logic [31:0] udp_byte_cnt;
        logic [8:0]  tcp_flow_cnt;
        logic [8:0]  udp_flow_cnt;
        int          mismatches;
        int          checked;
        int          n_hit;
        int          n_stored;
        int          n_full;
        int          n_skip;

        function new();
            total_cnt    = '0;
            tcp_pkt_cnt  = '0;
            udp_pkt_cnt  = '0;
            tcp_byte_cnt = '0;
            udp_byte_cnt = '0;
            tcp_flow_cnt = '0;
            udp_flow_cnt = '0;
            mismatches   = 0;
            checked      = 0;
            n_hit        = 0;
            n_stored     = 0;
            n_full       = 0;
            n_skip       = 0;
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
            mismatches++;
        endtask

        task compare_field(string what, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch(what, got, want);
        endtask

        // Update counters and flow table for one accepted packet, queue its result.
        function void note_packet(in_t p);
            out_t      r;
            flow_key_t k;
            int        hdr;
            int        slot;
            bit        udp;
            r = '0;
            total_cnt += 1;
            if (p.ip_protocol == PROTO_TCP || p.ip_protocol == PROTO_UDP)
            begin
                udp = (p.ip_protocol == PROTO_UDP);
                r.packet_kind = udp ? KIND_UDP : KIND_TCP;
                hdr = int'(ETH_HDR_BYTES) + 4 * int'(p.ip_header_words)
                    + (udp ? int'(UDP_HDR_BYTES) : 4 * int'(p.tcp_data_offset));
                if (int'(p.frame_length) > hdr)
                    r.payload_bytes = 16'(int'(p.frame_length) - hdr);
                if (udp)
                begin
                    udp_pkt_cnt  += 1;
                    udp_byte_cnt += 32'(p.frame_length);
                end
                else
                begin
                    tcp_pkt_cnt  += 1;
                    tcp_byte_cnt += 32'(p.frame_length);
                end
                k.udp   = udp;
                k.saddr = p.source_address;
                k.daddr = p.dest_address;
                k.ports = {p.source_port_num, p.dest_port_num};
                slot = -1;
                foreach (stored_flows[i])
                    if (slot < 0 && stored_flows[i] == k)
                        slot = i;
                if (slot >= 0)
                begin
                    r.flow_slot = 8'(slot);
                    n_hit++;
                end
                else
                begin
                    r.flow_is_new = 1'b1;
                    if (stored_flows.size() < DEF_FLOW_ENTRIES)
                    begin
                        r.flow_slot = 8'(stored_flows.size());
                        stored_flows.push_back(k);
                        if (udp)
                            udp_flow_cnt += 1;
                        else
                            tcp_flow_cnt += 1;
                        n_stored++;
                    end
                    else
                    begin
                        r.table_full = 1'b1;
                        n_full++;
                    end
                end
            end
            else
                n_skip++;
            r.total_packets  = total_cnt;
            r.tcp_packets    = tcp_pkt_cnt;
            r.udp_packets    = udp_pkt_cnt;
            r.tcp_byte_total = tcp_byte_cnt;
            r.udp_byte_total = udp_byte_cnt;
            r.tcp_flows      = tcp_flow_cnt;
            r.udp_flows      = udp_flow_cnt;
            pending_results.push_back(r);
        endfunction

        task check_result(out_t got);
            out_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with nothing pending", got.total_packets, '0);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            compare_field("packet_kind", got.packet_kind, want.packet_kind);
            compare_field("flow_is_new", got.flow_is_new, want.flow_is_new);
            compare_field("table_full", got.table_full, want.table_full);
            compare_field("flow_slot", got.flow_slot, want.flow_slot);
            compare_field("payload_bytes", got.payload_bytes, want.payload_bytes);
            compare_field("total_packets", got.total_packets, want.total_packets);
            compare_field("tcp_packets", got.tcp_packets, want.tcp_packets);
            compare_field("udp_packets", got.udp_packets, want.udp_packets);
            compare_field("tcp_byte_total", got.tcp_byte_total, want.tcp_byte_total);
            compare_field("udp_byte_total", got.udp_byte_total, want.udp_byte_total);
            compare_field("tcp_flows", got.tcp_flows, want.tcp_flows);
            compare_field("udp_flows", got.udp_flows, want.udp_flows);
        endtask
    endclass

    logic  clk;
    logic  rst_n;
    in_t   pkt;
    logic  pkt_valid;
    logic  pkt_stall;
    out_t  res;
    logic  res_valid;
    logic  res_stall;

    flow_scoreboard sb = new();
    bit             quiet;
    int             cycle_count;
    int             stall_left;

    five_tuple_flow_tracker i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (pkt),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .res       (res),
        .res_valid (res_valid),
        .res_stall (res_stall)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, sb.pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 30);
        return $urandom_range(100, 400);
    endfunction

    // Result side: take transfers and stall in random bursts.
    initial
    begin
        res_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (res_valid && !res_stall)
                sb.check_result(res);
            if (stall_left > 0)
                stall_left--;
            else if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            res_stall <= (stall_left > 0);
        end
    end

    task automatic send_packet(in_t p);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            pkt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pkt       <= p;
        pkt_valid <= 1'b1;
        @(posedge clk);
        while (pkt_stall)
            @(posedge clk);
        sb.note_packet(p);
    endtask

    task automatic send_fields(logic [7:0] proto, logic [3:0] ihl, logic [3:0] doff,
                               logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                               logic [15:0] dp, logic [15:0] flen);
        in_t p;
        p.ip_protocol     = proto;
        p.ip_header_words = ihl;
        p.tcp_data_offset = doff;
        p.source_address  = sa;
        p.dest_address    = da;
        p.source_port_num = sp;
        p.dest_port_num   = dp;
        p.frame_length    = flen;
        send_packet(p);
    endtask

    // Mix of skipped protocols, repeats of stored flows, near misses and new tuples.
    function automatic in_t make_random_packet();
        in_t       p;
        flow_key_t k;
        int        mode;
        int        bitpos;
        p = in_t'({$urandom, $urandom, $urandom, $urandom});
        mode = $urandom_range(0, 99);
        if (mode < 12)
            return p;
        p.ip_protocol = ($urandom_range(0, 1) == 1) ? PROTO_UDP : PROTO_TCP;
        if (mode < 62 && sb.stored_flows.size() != 0)
        begin
            k = sb.stored_flows[$urandom_range(0, sb.stored_flows.size() - 1)];
            p.ip_protocol     = k.udp ? PROTO_UDP : PROTO_TCP;
            p.source_address  = k.saddr;
            p.dest_address    = k.daddr;
            p.source_port_num = k.ports[31:16];
            p.dest_port_num   = k.ports[15:0];
            if (mode >= 50)
            begin
                bitpos = $urandom_range(0, 31);
                case ($urandom_range(0, 4))
                    0: p.source_address[bitpos] = ~p.source_address[bitpos];
                    1: p.dest_address[bitpos] = ~p.dest_address[bitpos];
                    2: p.source_port_num[bitpos % 16] = ~p.source_port_num[bitpos % 16];
                    3: p.dest_port_num[bitpos % 16] = ~p.dest_port_num[bitpos % 16];
                    default: p.ip_protocol = k.udp ? PROTO_TCP : PROTO_UDP;
                endcase
            end
        end
        if ($urandom_range(0, 2) == 0)
            p.frame_length = 16'($urandom_range(0, 140));
        return p;
    endfunction

    initial
    begin
        rst_n     = 1'b0;
        pkt_valid = 1'b0;
        pkt       = '0;
        quiet     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // zero tuple under both protocols, frame shorter than headers
        send_fields(PROTO_TCP, 4'd0, 4'd0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0);
        send_fields(PROTO_UDP, 4'd0, 4'd0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0);
        // all-ones fields
        send_fields(PROTO_TCP, 4'hf, 4'hf, 32'hffff_ffff, 32'hffff_ffff,
                    16'hffff, 16'hffff, 16'hffff);
        send_fields(PROTO_UDP, 4'hf, 4'hf, 32'hffff_ffff, 32'hffff_ffff,
                    16'hffff, 16'hffff, 16'hffff);
        // headers exactly fill the frame, then one byte of payload on the same flow
        send_fields(PROTO_TCP, 4'd5, 4'd5, 32'hc0a8_0001, 32'h0a00_0002,
                    16'd80, 16'd1234, 16'd54);
        send_fields(PROTO_TCP, 4'd5, 4'd5, 32'hc0a8_0001, 32'h0a00_0002,
                    16'd80, 16'd1234, 16'd55);
        // UDP ignores the data offset
        send_fields(PROTO_UDP, 4'd5, 4'd0, 32'hc0a8_0001, 32'h0a00_0002,
                    16'd53, 16'd5353, 16'd42);
        send_fields(PROTO_UDP, 4'd5, 4'hf, 32'hc0a8_0001, 32'h0a00_0002,
                    16'd53, 16'd5353, 16'd43);
        // hit on slot 0, near miss, swapped ports
        send_fields(PROTO_TCP, 4'd5, 4'd8, 32'h0, 32'h0, 16'h0, 16'h0, 16'd1500);
        send_fields(PROTO_TCP, 4'd5, 4'd5, 32'hc0a8_0000, 32'h0a00_0002,
                    16'd80, 16'd1234, 16'd1500);
        send_fields(PROTO_TCP, 4'd5, 4'd5, 32'hc0a8_0001, 32'h0a00_0002,
                    16'd1234, 16'd80, 16'd100);
        // skipped protocols next to the tracked ones
        send_fields(8'd0, 4'($urandom), 4'($urandom), $urandom, $urandom,
                    16'($urandom), 16'($urandom), 16'($urandom));
        send_fields(8'd255, 4'($urandom), 4'($urandom), $urandom, $urandom,
                    16'($urandom), 16'($urandom), 16'($urandom));
        send_fields(8'd5, 4'd5, 4'd5, 32'hc0a8_0001, 32'h0a00_0002,
                    16'd80, 16'd1234, 16'd1000);
        send_fields(8'd7, 4'd5, 4'd5, 32'hc0a8_0001, 32'h0a00_0002,
                    16'd80, 16'd1234, 16'd1000);
        send_fields(8'd16, 4'd5, 4'd0, 32'hc0a8_0001, 32'h0a00_0002,
                    16'd53, 16'd5353, 16'd1000);
        send_fields(8'd18, 4'd5, 4'd0, 32'hc0a8_0001, 32'h0a00_0002,
                    16'd53, 16'd5353, 16'd1000);

        for (int i = 0; i < RANDOM_PACKETS; i++)
        begin
            quiet = ((i / 200) % 3 == 2);
            send_packet(make_random_packet());
        end
        pkt_valid <= 1'b0;
        quiet = 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d results over %0d cycles, %0d mismatches",
                 sb.checked, cycle_count, sb.mismatches);
        $display("flows: %0d stored, %0d matched, %0d rejected on full table, %0d skipped",
                 sb.n_stored, sb.n_hit, sb.n_full, sb.n_skip);
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/fftr_pkg.sv
hdl/fftr_front.sv
hdl/fftr_cell.sv
hdl/five_tuple_flow_tracker.sv
verif/five_tuple_flow_tracker_tb.sv
